// ===== hdl/sine_oscillator_bank_mixer_macros.svh =====
// Assertion macros for the sine oscillator bank mixer, clocked on i_clk, reset by i_rst_n.
`ifndef SINE_OSCILLATOR_BANK_MIXER_MACROS_SVH
`define SINE_OSCILLATOR_BANK_MIXER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SOBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sobm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SOBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sobm assertion failed");

`endif

// ===== hdl/sobm_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the oscillator bank.
package sobm_pkg;

    localparam int OSC_COUNT       = 12;
    localparam int SINE_TABLE_BITS = 10;

    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int QA_W    = SINE_TABLE_BITS - 1;
    localparam int CNT_W   = (OSC_COUNT > 1) ? $clog2(OSC_COUNT) : 1;
    localparam int CH_W    = $clog2(OSC_COUNT + 1);

    // mean: sum width, reciprocal shift and reciprocal constant
    localparam int SUM_W   = 16 + $clog2(OSC_COUNT);
    localparam int DIV_K   = SUM_W + 2 * $clog2(OSC_COUNT);
    localparam int RECIP_W = DIV_K - $clog2(OSC_COUNT) + 1;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << DIV_K) + 64'(OSC_COUNT) - 64'd1)
                                         / 64'(OSC_COUNT);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W  = SUM_W + RECIP_W;

    localparam int CFG_DATA_W = 32;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BASE_STEP = 2'd0;
    localparam t_cfg_idx CFG_FREQ_GAIN = 2'd1;
    localparam t_cfg_idx CFG_AMP_GAIN  = 2'd2;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [31:0] BASE_STEP_RST = 32'd4473924;
    localparam logic signed [12:0] FREQ_GAIN_RST = 13'sd256;
    localparam logic [15:0] AMP_GAIN_RST = 16'd32768;

    typedef struct packed {
        logic signed [23:0] freq_ofs;
        logic signed [15:0] amp_ofs;
    } t_ofs;

    typedef struct packed {
        logic [31:0] phase;
        t_ofs        ofs;
    } t_osc;

    typedef struct packed {
        logic rot;
        logic load;
        logic smp_shift;
    } t_cell_ctl;

    typedef struct packed {
        logic clr;
        logic add;
        logic start;
    } t_mean_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_MEAN,
        S_AVG,
        S_SMP
    } t_state;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

    typedef logic [QUARTER:0][15:0] t_qsine;

    // quarter wave from a fixed-point Taylor series, evaluated at elaboration
    function automatic t_qsine build_qsine();
        t_qsine      tab;
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] q;
        for (int r = 0; r <= QUARTER; r++) begin
            theta = (64'(r) * TWO_PI_Q30) >> SINE_TABLE_BITS;
            t2    = (theta * theta) >> 30;
            p     = ONE_Q30;
            p     = ONE_Q30 - (((t2 * p) >> 30) / 64'd110);
            p     = ONE_Q30 - (((t2 * p) >> 30) / 64'd72);
            p     = ONE_Q30 - (((t2 * p) >> 30) / 64'd42);
            p     = ONE_Q30 - (((t2 * p) >> 30) / 64'd20);
            p     = ONE_Q30 - (((t2 * p) >> 30) / 64'd6);
            s     = (theta * p) >> 30;
            q     = (s + 64'd16384) >> 15;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            tab[r] = q[15:0];
        end
        return tab;
    endfunction

    localparam t_qsine SINE_Q = build_qsine();

endpackage

// ===== hdl/sobm_in_if.sv =====
// Request channel: tick or offset load.
interface sobm_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [3:0]         osc_index;
    logic signed [23:0] freq_offset;
    logic signed [15:0] amp_offset;

    modport source (output valid, req_type, osc_index, freq_offset, amp_offset, input ready);
    modport sink   (input valid, req_type, osc_index, freq_offset, amp_offset, output ready);
endinterface

// ===== hdl/sobm_out_if.sv =====
// Result channel: mix and per-oscillator samples.
interface sobm_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel;
    logic signed [15:0] sample;
    logic               last;

    modport source (output valid, channel, sample, last, input ready);
    modport sink   (input valid, channel, sample, last, output ready);
endinterface

// ===== hdl/sobm_cell.sv =====
// One oscillator cell: phase, offsets and a sample slot, each shifting to the neighbor.
module sobm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sobm_pkg::t_cell_ctl i_ctl,
    input  sobm_pkg::t_osc     i_next,
    input  sobm_pkg::t_ofs     i_load,
    input  logic signed [15:0] i_smp_next,
    output sobm_pkg::t_osc     o_osc,
    output logic signed [15:0] o_smp
);
    import sobm_pkg::*;

    t_osc               r_osc;
    logic signed [15:0] r_smp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc <= '0;
        end else if (i_ctl.load) begin
            r_osc.ofs <= i_load;
        end else if (i_ctl.rot) begin
            r_osc <= i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.smp_shift) begin
            r_smp <= i_smp_next;
        end
    end

    assign o_osc = r_osc;
    assign o_smp = r_smp;
endmodule

// ===== hdl/sobm_voice.sv =====
// Shared voice unit: phase advance of the head cell and a two-stage amplitude x sine pipeline.
module sobm_voice (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  sobm_pkg::t_osc     i_head,
    input  logic [31:0]        i_base,
    input  logic signed [12:0] i_fgain,
    input  logic [15:0]        i_again,
    output sobm_pkg::t_osc     o_adv,
    output logic               o_valid,
    output logic               o_busy,
    output logic signed [15:0] o_smp
);
    import sobm_pkg::*;

    logic signed [36:0]          fprod;
    logic [31:0]                 step;
    logic [SINE_TABLE_BITS-1:0]  idx;
    logic [1:0]                  quad;
    logic [QA_W-1:0]             addr;
    logic signed [15:0]          sine;
    logic signed [32:0]          aprod;
    logic signed [17:0]          amp;
    logic signed [33:0]          prod;
    logic signed [18:0]          shifted;
    logic signed [15:0]          sat;

    logic                        r_v1;
    logic                        r_v2;
    logic signed [15:0]          r_sine;
    logic signed [17:0]          r_amp;
    logic signed [15:0]          r_smp;

    always_comb begin
        fprod       = $signed(i_head.ofs.freq_ofs) * i_fgain;
        step        = i_base + 32'($signed(fprod[36:8]));
        o_adv.phase = i_head.phase + step;
        o_adv.ofs   = i_head.ofs;

        idx  = i_head.phase[31 -: SINE_TABLE_BITS];
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        if (quad[0]) begin
            addr = QA_W'(QUARTER) - QA_W'(idx[SINE_TABLE_BITS-3:0]);
        end else begin
            addr = QA_W'(idx[SINE_TABLE_BITS-3:0]);
        end
        sine = quad[1] ? -$signed(SINE_Q[addr]) : $signed(SINE_Q[addr]);

        aprod = $signed(i_head.ofs.amp_ofs) * $signed({1'b0, i_again});
        amp   = 18'sd32768 + $signed(aprod[32:15]);
    end

    always_comb begin
        prod    = r_amp * r_sine;
        shifted = prod[33:15];
        if (shifted > 19'sd32767) begin
            sat = 16'sh7FFF;
        end else if (shifted < -19'sd32768) begin
            sat = 16'sh8000;
        end else begin
            sat = shifted[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_go;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sine <= sine;
        r_amp  <= amp;
        r_smp  <= sat;
    end

    assign o_valid = r_v2;
    assign o_busy  = r_v1 | r_v2;
    assign o_smp   = r_smp;
endmodule

// ===== hdl/sobm_mean.sv =====
// Sample accumulator and truncating divide by the oscillator count via a reciprocal multiply.
module sobm_mean (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sobm_pkg::t_mean_ctl i_ctl,
    input  logic signed [15:0] i_smp,
    output logic               o_done,
    output logic signed [15:0] o_avg
);
    import sobm_pkg::*;

    logic signed [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0]        r_mag;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_neg1;
    logic                    r_neg2;
    logic signed [15:0]      r_avg;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic [15:0]             quot;

    assign quot = r_prod[DIV_K +: 16];

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.add) begin
            r_sum <= r_sum + SUM_W'(i_smp);
        end
        r_neg1 <= r_sum[SUM_W-1];
        r_mag  <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        r_neg2 <= r_neg1;
        r_prod <= PROD_W'(r_mag) * PROD_W'(RECIP);
        r_avg  <= r_neg2 ? -$signed(quot) : $signed(quot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_done = r_v3;
    assign o_avg  = r_avg;
endmodule

// ===== hdl/sine_oscillator_bank_mixer.sv =====
// Top level: ring of oscillator cells, shared voice unit, mean unit and sequencer.
//
//   port     dir  carries
//   i_req    in   tick or offset load (req_type, osc_index, freq_offset, amp_offset)
//   o_res    out  mix then one sample per oscillator (channel, sample, last)
//   i_cfg_*  in   register writes (base step, frequency gain, amplitude gain)
//
// A load writes the offsets of one cell. A tick first takes the request, then the ring
// rotates once through the voice unit (one oscillator per cycle), the voice pipeline
// drains, the mean unit forms the mix, and OSC_COUNT + 1 results leave one per cycle
// while o_res is ready.
// Requests are taken only while no tick is in progress; o_res stalls hold the sample shift.
// Synchronous reset clears phases, offsets and registers to their defaults.
`include "sine_oscillator_bank_mixer_macros.svh"

module sine_oscillator_bank_mixer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sobm_in_if.sink                        i_req,
    sobm_out_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  sobm_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [sobm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sobm_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [CH_W-1:0]    r_chan;
    logic [CH_W-1:0]    n_chan;

    logic [31:0]        r_base;
    logic signed [12:0] r_fgain;
    logic [15:0]        r_again;

    logic               acc_in;
    logic               rot;
    logic               out_shift;
    logic               last;
    t_mean_ctl          mean_ctl;

    t_osc               w_osc [OSC_COUNT];
    logic signed [15:0] w_smp [OSC_COUNT];
    t_cell_ctl          w_ctl [OSC_COUNT];
    t_osc               w_adv;
    t_ofs               load_ofs;
    logic               voice_valid;
    logic               voice_busy;
    logic signed [15:0] voice_smp;
    logic               mean_done;
    logic signed [15:0] mean_avg;

    assign acc_in   = i_req.valid && (r_state == S_IDLE);
    assign load_ofs = '{freq_ofs: i_req.freq_offset, amp_ofs: i_req.amp_offset};
    assign last     = (r_state == S_SMP) && (r_chan == CH_W'(OSC_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_STEP_RST;
            r_fgain <= FREQ_GAIN_RST;
            r_again <= AMP_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_STEP: r_base  <= i_cfg_data[31:0];
                CFG_FREQ_GAIN: r_fgain <= $signed(i_cfg_data[12:0]);
                CFG_AMP_GAIN:  r_again <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_chan  <= n_chan;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_chan    = r_chan;
        rot       = 1'b0;
        out_shift = 1'b0;
        mean_ctl  = '0;
        case (r_state)
            S_IDLE: begin
                if (acc_in && (i_req.req_type == REQ_TICK)) begin
                    n_state      = S_RUN;
                    n_cnt        = '0;
                    mean_ctl.clr = 1'b1;
                end
            end
            S_RUN: begin
                rot   = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(OSC_COUNT - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!voice_busy) begin
                    mean_ctl.start = 1'b1;
                    n_state        = S_MEAN;
                end
            end
            S_MEAN: begin
                if (mean_done) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                if (o_res.ready) begin
                    n_state = S_SMP;
                    n_chan  = CH_W'(1);
                end
            end
            S_SMP: begin
                if (o_res.ready) begin
                    out_shift = 1'b1;
                    n_chan    = r_chan + 1'b1;
                    if (last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        mean_ctl.add = voice_valid;
    end

    for (genvar g = 0; g < OSC_COUNT; g++) begin : g_cell
        t_osc               next_osc;
        logic signed [15:0] next_smp;

        if (g == OSC_COUNT - 1) begin : g_tail
            assign next_osc = w_adv;
            assign next_smp = voice_smp;
        end else begin : g_body
            assign next_osc = w_osc[g+1];
            assign next_smp = w_smp[g+1];
        end

        assign w_ctl[g].rot       = rot;
        assign w_ctl[g].load      = acc_in && (i_req.req_type == REQ_LOAD)
                                    && (32'(i_req.osc_index) == g);
        assign w_ctl[g].smp_shift = voice_valid | out_shift;

        sobm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_next     (next_osc),
            .i_load     (load_ofs),
            .i_smp_next (next_smp),
            .o_osc      (w_osc[g]),
            .o_smp      (w_smp[g])
        );
    end

    sobm_voice u_voice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (rot),
        .i_head  (w_osc[0]),
        .i_base  (r_base),
        .i_fgain (r_fgain),
        .i_again (r_again),
        .o_adv   (w_adv),
        .o_valid (voice_valid),
        .o_busy  (voice_busy),
        .o_smp   (voice_smp)
    );

    sobm_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mean_ctl),
        .i_smp   (voice_smp),
        .o_done  (mean_done),
        .o_avg   (mean_avg)
    );

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_res.valid   = (r_state == S_AVG) || (r_state == S_SMP);
    assign o_res.channel = (r_state == S_AVG) ? 4'd0 : 4'(r_chan);
    assign o_res.sample  = (r_state == S_AVG) ? mean_avg : w_smp[0];
    assign o_res.last    = last;

    `SOBM_ASSERT_NOW(a_no_req_during_results, o_res.valid, !i_req.ready)
    `SOBM_ASSERT_NOW(a_mix_leads, $rose(o_res.valid), o_res.channel == 4'd0)
    `SOBM_ASSERT_NEXT(a_tick_closes_input, i_req.valid && i_req.ready && i_req.req_type == REQ_TICK, !i_req.ready)
    `SOBM_ASSERT_NEXT(a_last_ends_tick, o_res.valid && o_res.ready && o_res.last, !o_res.valid)
endmodule
